// File: hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and widths for the vector normalization pipeline
// Holds the word formats of both channels, the datapath widths derived from
// the component and fraction widths, and the control group of one stage.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Field widths of the words on both channels.
  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam int LANES     = 4;

  // Datapath widths.
  localparam int MAG_W  = COMP_BITS;          // magnitude of one component
  localparam int SQ_W   = 2 * COMP_BITS - 1;  // square of one magnitude
  localparam int SUM_W  = 2 * COMP_BITS + 1;  // sum of four squares
  localparam int DIV_W  = SUM_W + 1;          // shifted partial remainder
  localparam int QUO_W  = 2 * FRAC_BITS + 1;  // square of a unit value
  localparam int UNIT_W = FRAC_BITS + 1;      // unit value, Q1.FRAC_BITS
  localparam int LEN_W  = COMP_BITS + 1;      // integer length

  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
    logic signed [COMP_BITS-1:0] comp_w;
  } item_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic signed [UNIT_W-1:0] unit_w;
    logic [LEN_W-1:0]         length;
    logic                     zero_vector;
  } result_t;

  // Control that travels with a word through every stage.
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
  } ctl_t;

  typedef logic [LANES-1:0][SQ_W-1:0] sq_vec_t;

endpackage

// File: hw/rtl/vn_front.sv
// ----------------------------------------------------------------------------
// vn_front: magnitudes, squares and sum of squares
// Three registered stages: sign and magnitude of each component, the four
// squares, then their sum together with the zero-vector flag.
// ----------------------------------------------------------------------------
module vn_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  vn_pkg::item_t              item,
  output vn_pkg::ctl_t               ctl,
  output vn_pkg::sq_vec_t            sq,
  output logic [vn_pkg::SUM_W-1:0]   sum
);
  import vn_pkg::*;

  logic [LANES-1:0][COMP_BITS-1:0] raw;
  logic [LANES-1:0][MAG_W-1:0]     mag_comb;
  logic [LANES-1:0][MAG_W-1:0]     mag;
  logic [LANES-1:0]                neg_comb;
  logic [LANES-1:0]                neg_a;
  logic [LANES-1:0]                neg_b;
  sq_vec_t                         sq_b;
  logic                            valid_a;
  logic                            valid_b;

  assign raw[0] = item.comp_x;
  assign raw[1] = item.comp_y;
  assign raw[2] = item.comp_z;
  assign raw[3] = item.comp_w;

  // Sign and magnitude; the most negative value maps to its true magnitude.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_comb[l] = raw[l][COMP_BITS-1];
      mag_comb[l] = neg_comb[l] ? MAG_W'(~raw[l] + 1'b1) : MAG_W'(raw[l]);
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      valid_a   <= valid_in;
      valid_b   <= valid_a;
      ctl.valid <= valid_b;
    end
  end

  // Datapath of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= mag_comb;
      neg_a <= neg_comb;
      for (int l = 0; l < LANES; l++) begin
        sq_b[l] <= SQ_W'(32'(mag[l]) * 32'(mag[l]));
      end
      neg_b    <= neg_a;
      sq       <= sq_b;
      sum      <= SUM_W'(sq_b[0]) + SUM_W'(sq_b[1]) + SUM_W'(sq_b[2]) + SUM_W'(sq_b[3]);
      ctl.neg  <= neg_b;
      ctl.zero <= ~|sq_b;
    end
  end

endmodule

// File: hw/rtl/vn_div_cell.sv
// ----------------------------------------------------------------------------
// vn_div_cell: one restoring division step
// Develops one quotient bit of square / sum per enabled cycle and passes the
// partial remainder and the quotient so far to the next cell.
// ----------------------------------------------------------------------------
module vn_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vn_pkg::SUM_W-1:0]  d,
  input  logic [vn_pkg::SUM_W-1:0]  rem_in,
  input  logic [vn_pkg::QUO_W-1:0]  quo_in,
  output logic [vn_pkg::SUM_W-1:0]  rem,
  output logic [vn_pkg::QUO_W-1:0]  quo
);
  import vn_pkg::*;

  logic [DIV_W-1:0] work;
  logic [DIV_W-1:0] diff;
  logic             fits;

  // The first cell tests the square itself; later cells shift one bit in.
  always_comb begin
    work = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
    diff = work - {1'b0, d};
    fits = (work >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= fits ? SUM_W'(diff) : SUM_W'(work);
      quo <= {quo_in[QUO_W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/vn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vn_sqrt_cell: one digit-by-digit square root step
// Brings down the next two radicand bits, tests the trial value and
// develops one root bit per enabled cycle.
// ----------------------------------------------------------------------------
module vn_sqrt_cell #(
  parameter int W    = 16,
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*W-1:0]   n_in,
  input  logic [W-1:0]     root_in,
  input  logic [W+1:0]     rem_in,
  output logic [2*W-1:0]   n,
  output logic [W-1:0]     root,
  output logic [W+1:0]     rem
);

  logic [1:0]   pair;
  logic [W+1:0] work;
  logic [W+1:0] trial;
  logic         fits;

  // Before the last step the remainder is below 2^W, so its low bits suffice.
  always_comb begin
    pair  = n_in[2*W-1-2*STEP -: 2];
    work  = {rem_in[W-1:0], pair};
    trial = {root_in, 2'b01};
    fits  = (work >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n    <= n_in;
      rem  <= fits ? (work - trial) : work;
      root <= {root_in[W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/vec4_normalize.sv
// ----------------------------------------------------------------------------
// vec4_normalize: four-component vector normalization to Q1.15
// Takes a vector of four signed components and returns the unit vector,
// the integer length and a zero-vector flag.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (item_valid, item_stall, item) takes one word per
//   vector; the output channel (result_valid, result_stall, result) gives
//   one word per vector, in order.
//   The pipeline holds 3 front stages, 31 division cells, 16 square
//   root cells and the output register.
//   Throughput is one vector per cycle; the chain of cells accepts a new
//   word in every cycle in which the output register is free or taken.
//   Each unit component is the square root of its squared share of the
//   sum of squares, so every lane runs a division chain then a root chain.
//   The length root runs in the first 17 division stages.
//   A zero vector gives zero components, zero length and the flag set.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and item_stall is raised in the same cycle.
//   Reset clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module vec4_normalize (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  vn_pkg::item_t     item,
  output logic              result_valid,
  input  logic              result_stall,
  output vn_pkg::result_t   result
);
  import vn_pkg::*;

  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_STEPS = UNIT_W;
  localparam logic [UNIT_W-1:0] UNIT_MAX = {1'b0, {FRAC_BITS{1'b1}}};

  logic    en;
  sq_vec_t sq;

  // Division section: one stage per quotient bit.
  ctl_t                         dctl  [DIV_STEPS+1];
  logic [SUM_W-1:0]             dsum  [DIV_STEPS+1];
  logic [LANES-1:0][SUM_W-1:0]  drem  [DIV_STEPS+1];
  logic [LANES-1:0][QUO_W-1:0]  dquo  [DIV_STEPS+1];
  logic [LEN_W-1:0]             lroot [DIV_STEPS+1];
  logic [2*LEN_W-1:0]           ln    [LEN_W+1];
  logic [LEN_W+1:0]             lrem  [LEN_W+1];

  // Root section: one stage per unit bit.
  ctl_t                            rctl  [ROOT_STEPS+1];
  logic [LEN_W-1:0]                rlen  [ROOT_STEPS+1];
  logic [LANES-1:0][2*UNIT_W-1:0]  rn    [ROOT_STEPS+1];
  logic [LANES-1:0][UNIT_W-1:0]    rroot [ROOT_STEPS+1];
  logic [LANES-1:0][UNIT_W+1:0]    rrem  [ROOT_STEPS+1];

  logic [LANES-1:0][UNIT_W-1:0]    unit_comb;

  // The chain advances whenever the output register is empty or taken.
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  vn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (item_valid),
    .item     (item),
    .ctl      (dctl[0]),
    .sq       (sq),
    .sum      (dsum[0])
  );

  // Seeds of the division and length chains.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      drem[0][l] = SUM_W'(sq[l]);
      dquo[0][l] = '0;
    end
    lroot[0] = '0;
    ln[0]    = (2*LEN_W)'(dsum[0]);
    lrem[0]  = '0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    // Control and divisor travel with the word.
    always_ff @(posedge clk) begin
      if (rst) begin
        dctl[i+1].valid <= 1'b0;
      end else if (en) begin
        dctl[i+1].valid <= dctl[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dctl[i+1].zero <= dctl[i].zero;
        dctl[i+1].neg  <= dctl[i].neg;
        dsum[i+1]      <= dsum[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      vn_div_cell #(
        .FIRST (i == 0)
      ) u_div (
        .clk    (clk),
        .en     (en),
        .d      (dsum[i]),
        .rem_in (drem[i][l]),
        .quo_in (dquo[i][l]),
        .rem    (drem[i+1][l]),
        .quo    (dquo[i+1][l])
      );
    end

    // Length root shares the first stages; afterwards the root is carried.
    if (i < LEN_W) begin : g_len
      vn_sqrt_cell #(
        .W    (LEN_W),
        .STEP (i)
      ) u_len (
        .clk     (clk),
        .en      (en),
        .n_in    (ln[i]),
        .root_in (lroot[i]),
        .rem_in  (lrem[i]),
        .n       (ln[i+1]),
        .root    (lroot[i+1]),
        .rem     (lrem[i+1])
      );
    end else begin : g_len_hold
      always_ff @(posedge clk) begin
        if (en) begin
          lroot[i+1] <= lroot[i];
        end
      end
    end
  end

  // Seeds of the root chains: the quotient is the squared unit value.
  always_comb begin
    rctl[0] = dctl[DIV_STEPS];
    rlen[0] = lroot[DIV_STEPS];
    for (int l = 0; l < LANES; l++) begin
      rn[0][l]    = (2*UNIT_W)'(dquo[DIV_STEPS][l]);
      rroot[0][l] = '0;
      rrem[0][l]  = '0;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) begin
        rctl[j+1].valid <= 1'b0;
      end else if (en) begin
        rctl[j+1].valid <= rctl[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rctl[j+1].zero <= rctl[j].zero;
        rctl[j+1].neg  <= rctl[j].neg;
        rlen[j+1]      <= rlen[j];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      vn_sqrt_cell #(
        .W    (UNIT_W),
        .STEP (j)
      ) u_root (
        .clk     (clk),
        .en      (en),
        .n_in    (rn[j][l]),
        .root_in (rroot[j][l]),
        .rem_in  (rrem[j][l]),
        .n       (rn[j+1][l]),
        .root    (rroot[j+1][l]),
        .rem     (rrem[j+1][l])
      );
    end
  end

  // Sign, saturation of exactly +1.0 and the zero-vector override.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rctl[ROOT_STEPS].zero) begin
        unit_comb[l] = '0;
      end else if (rctl[ROOT_STEPS].neg[l]) begin
        unit_comb[l] = UNIT_W'(~rroot[ROOT_STEPS][l] + 1'b1);
      end else if (rroot[ROOT_STEPS][l] > UNIT_MAX) begin
        unit_comb[l] = UNIT_MAX;
      end else begin
        unit_comb[l] = rroot[ROOT_STEPS][l];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= rctl[ROOT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.unit_x      <= unit_comb[0];
      result.unit_y      <= unit_comb[1];
      result.unit_z      <= unit_comb[2];
      result.unit_w      <= unit_comb[3];
      result.length      <= rctl[ROOT_STEPS].zero ? '0 : rlen[ROOT_STEPS];
      result.zero_vector <= rctl[ROOT_STEPS].zero;
    end
  end

endmodule
